/* src/alst_pkg.sv */
// Shared types and codes for the array list engine.
// Depends on nothing; alst_seq and the core module refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package alst_pkg;

   // Action codes carried by a request transaction.
   localparam logic [3:0] ACT_APPEND    = 4'd0;
   localparam logic [3:0] ACT_INSERT    = 4'd1;
   localparam logic [3:0] ACT_DROP_LAST = 4'd2;
   localparam logic [3:0] ACT_DELETE_AT = 4'd3;
   localparam logic [3:0] ACT_SEARCH    = 4'd4;
   localparam logic [3:0] ACT_REVERSE   = 4'd5;
   localparam logic [3:0] ACT_SHL       = 4'd6;
   localparam logic [3:0] ACT_ROTL      = 4'd7;
   localparam logic [3:0] ACT_SHR       = 4'd8;
   localparam logic [3:0] ACT_ROTR      = 4'd9;
   localparam logic [3:0] ACT_PARTITION = 4'd10;
   localparam logic [3:0] ACT_READ      = 4'd11;

   // Status codes carried by a response transaction.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_BAD_INDEX = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // One finished result as it travels from the sequencer to the output stage.
   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  found_at;
      logic [31:0] read_data;
      logic [6:0]  list_length;
   } rsp_type;

endpackage

`default_nettype wire

/* src/alst_req_if.sv */
// Request and response channel interfaces of the array list engine.
// Depends on nothing beyond the language; payload widths are fixed.
`timescale 1ns / 1ps
`default_nettype none

interface alst_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [5:0]  position;
   logic [31:0] item_value;

   modport source (output valid, output action, output position, output item_value,
                   input ready);
   modport sink   (input valid, input action, input position, input item_value,
                   output ready);
endinterface

interface alst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  found_at;
   logic [31:0] read_data;
   logic [6:0]  list_length;

   modport source (output valid, output status, output found_at, output read_data,
                   output list_length, input ready);
   modport sink   (input valid, input status, input found_at, input read_data,
                   input list_length, output ready);
endinterface

`default_nettype wire

/* src/alst_mem.sv */
// Entry store of the array list engine: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module alst_mem #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WORD_BITS-1:0]       wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WORD_BITS-1:0]       rd_data
);

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write and read are both synchronous; read data is registered and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/alst_seq.sv */
// Action sequencer: walks the entry store one access at a time for each request.
// Depends on alst_pkg for action, status and result types.
`timescale 1ns / 1ps
`default_nettype none

module alst_seq #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32,
   localparam int LEN_BITS  = $clog2(DEPTH + 1),
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [3:0]             req_action,
   input  wire logic [5:0]             req_position,
   input  wire logic [31:0]            req_item_value,
   input  wire logic [LEN_BITS-1:0]    capacity,
   // result side
   output      logic                   done,
   input  wire logic                   done_ack,
   output      alst_pkg::rsp_type      result,
   // entry store
   output      logic                   wr_en,
   output      logic [ADDR_BITS-1:0]   wr_addr,
   output      logic [WORD_BITS-1:0]   wr_data,
   output      logic [ADDR_BITS-1:0]   rd_addr,
   input  wire logic [WORD_BITS-1:0]   rd_data
);

   localparam int CW = (LEN_BITS > 7) ? LEN_BITS : 7;

   typedef enum logic [18:0] {
      S_IDLE     = 19'b0000000000000000001,
      S_GET      = 19'b0000000000000000010,
      S_LATCH    = 19'b0000000000000000100,
      S_RD       = 19'b0000000000000001000,
      S_WR       = 19'b0000000000000010000,
      S_TAIL     = 19'b0000000000000100000,
      S_SRCH_RD  = 19'b0000000000001000000,
      S_SRCH_CHK = 19'b0000000000010000000,
      S_SWAP2    = 19'b0000000000100000000,
      S_REV_RA   = 19'b0000000001000000000,
      S_REV_RB   = 19'b0000000010000000000,
      S_REV_WA   = 19'b0000000100000000000,
      S_REV_WB   = 19'b0000001000000000000,
      S_PA       = 19'b0000010000000000000,
      S_PA_CHK   = 19'b0000100000000000000,
      S_PB       = 19'b0001000000000000000,
      S_PB_CHK   = 19'b0010000000000000000,
      S_PW       = 19'b0100000000000000000,
      S_DONE     = 19'b1000000000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [LEN_BITS-1:0]   len_nx_ff, len_nx_in;
   logic [LEN_BITS-1:0]   i_ff, i_in;       // loop index, also pointer a
   logic [LEN_BITS-1:0]   end_ff, end_in;   // loop end, also pointer b
   logic                  down_ff, down_in;
   logic                  tail_we_ff, tail_we_in;
   logic                  use_t_ff, use_t_in;
   logic [LEN_BITS-1:0]   tail_addr_ff, tail_addr_in;
   logic [WORD_BITS-1:0]  tdat_ff, tdat_in;
   logic [WORD_BITS-1:0]  t_ff, t_in;
   logic [WORD_BITS-1:0]  x_ff, x_in;
   logic [LEN_BITS-1:0]   tsrc_ff, tsrc_in;
   logic                  rd_out_ff, rd_out_in;
   logic [2:0]            status_ff, status_in;
   logic [5:0]            found_ff, found_in;
   logic [31:0]           rdata_ff, rdata_in;

   logic signed [63:0]    x_wide;
   logic signed [63:0]    r_wide;
   logic [CW-1:0]         len_c, pos_c, cap_c;
   logic                  full, empty;
   logic [LEN_BITS-1:0]   pos_l, len_m1, i_p1, i_m1, b_m1;

   assign x_wide = 64'(signed'(req_item_value));
   assign r_wide = 64'(signed'(rd_data));
   assign len_c  = CW'(len_ff);
   assign pos_c  = CW'(req_position);
   assign cap_c  = CW'(capacity);
   assign full   = len_c >= cap_c;
   assign empty  = (len_ff == '0);
   assign pos_l  = LEN_BITS'(pos_c);
   assign len_m1 = LEN_BITS'(len_ff - 1'b1);
   assign i_p1   = LEN_BITS'(i_ff + 1'b1);
   assign i_m1   = LEN_BITS'(i_ff - 1'b1);
   assign b_m1   = LEN_BITS'(end_ff - 1'b1);

   assign req_ready = (state_ff == S_IDLE);
   assign done      = (state_ff == S_DONE);

   assign result.status      = status_ff;
   assign result.found_at    = found_ff;
   assign result.read_data   = rdata_ff;
   assign result.list_length = 7'(len_ff);

   // Next-state and store access logic.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      len_nx_in    = len_nx_ff;
      i_in         = i_ff;
      end_in       = end_ff;
      down_in      = down_ff;
      tail_we_in   = tail_we_ff;
      use_t_in     = use_t_ff;
      tail_addr_in = tail_addr_ff;
      tdat_in      = tdat_ff;
      t_in         = t_ff;
      x_in         = x_ff;
      tsrc_in      = tsrc_ff;
      rd_out_in    = rd_out_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rdata_in     = rdata_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff[ADDR_BITS-1:0];
      wr_data      = rd_data;
      rd_addr      = i_ff[ADDR_BITS-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in       = x_wide[WORD_BITS-1:0];
               status_in  = alst_pkg::ST_OK;
               found_in   = '0;
               rdata_in   = '0;
               tail_we_in = 1'b0;
               use_t_in   = 1'b0;
               tdat_in    = x_wide[WORD_BITS-1:0];
               len_nx_in  = len_ff;
               rd_out_in  = 1'b0;
               state_in   = S_DONE;
               unique case (req_action)
                  alst_pkg::ACT_APPEND: begin
                     if (full) begin
                        status_in = alst_pkg::ST_FULL;
                     end else begin
                        tail_we_in   = 1'b1;
                        tail_addr_in = len_ff;
                        len_nx_in    = LEN_BITS'(len_ff + 1'b1);
                        state_in     = S_TAIL;
                     end
                  end
                  alst_pkg::ACT_INSERT: begin
                     if (pos_c > len_c) begin
                        status_in = alst_pkg::ST_BAD_INDEX;
                     end else if (full) begin
                        status_in = alst_pkg::ST_FULL;
                     end else begin
                        i_in         = len_ff;
                        end_in       = pos_l;
                        down_in      = 1'b1;
                        tail_we_in   = 1'b1;
                        tail_addr_in = pos_l;
                        len_nx_in    = LEN_BITS'(len_ff + 1'b1);
                        state_in     = S_RD;
                     end
                  end
                  alst_pkg::ACT_DROP_LAST: begin
                     if (empty) begin
                        status_in = alst_pkg::ST_EMPTY;
                     end else begin
                        len_nx_in = len_m1;
                        state_in  = S_TAIL;
                     end
                  end
                  alst_pkg::ACT_DELETE_AT: begin
                     if (empty) begin
                        status_in = alst_pkg::ST_EMPTY;
                     end else if (pos_c >= len_c) begin
                        status_in = alst_pkg::ST_BAD_INDEX;
                     end else begin
                        i_in      = pos_l;
                        end_in    = len_m1;
                        down_in   = 1'b0;
                        len_nx_in = len_m1;
                        state_in  = S_RD;
                     end
                  end
                  alst_pkg::ACT_SEARCH: begin
                     if (empty) begin
                        status_in = alst_pkg::ST_EMPTY;
                     end else begin
                        i_in     = '0;
                        state_in = S_SRCH_RD;
                     end
                  end
                  alst_pkg::ACT_REVERSE: begin
                     i_in   = '0;
                     end_in = len_m1;
                     if (!empty) begin
                        state_in = S_REV_RA;
                     end
                  end
                  alst_pkg::ACT_SHL, alst_pkg::ACT_ROTL: begin
                     if (empty) begin
                        status_in = alst_pkg::ST_EMPTY;
                     end else begin
                        tsrc_in      = '0;
                        i_in         = '0;
                        end_in       = len_m1;
                        down_in      = 1'b0;
                        tail_we_in   = 1'b1;
                        tail_addr_in = len_m1;
                        use_t_in     = (req_action == alst_pkg::ACT_ROTL);
                        tdat_in      = '0;
                        state_in     = S_GET;
                     end
                  end
                  alst_pkg::ACT_SHR, alst_pkg::ACT_ROTR: begin
                     if (empty) begin
                        status_in = alst_pkg::ST_EMPTY;
                     end else begin
                        tsrc_in      = len_m1;
                        i_in         = len_m1;
                        end_in       = '0;
                        down_in      = 1'b1;
                        tail_we_in   = 1'b1;
                        tail_addr_in = '0;
                        use_t_in     = (req_action == alst_pkg::ACT_ROTR);
                        tdat_in      = '0;
                        state_in     = S_GET;
                     end
                  end
                  alst_pkg::ACT_PARTITION: begin
                     i_in   = '0;
                     end_in = len_m1;
                     if (!empty) begin
                        state_in = S_PA;
                     end
                  end
                  alst_pkg::ACT_READ: begin
                     if (pos_c >= len_c) begin
                        status_in = alst_pkg::ST_BAD_INDEX;
                     end else begin
                        tsrc_in   = pos_l;
                        rd_out_in = 1'b1;
                        state_in  = S_GET;
                     end
                  end
                  default: begin
                     status_in = alst_pkg::ST_BAD_INDEX;
                  end
               endcase
            end
         end

         // Fetch one word: the saved end word of a shift, or the word of a read.
         S_GET: begin
            rd_addr  = tsrc_ff[ADDR_BITS-1:0];
            state_in = S_LATCH;
         end
         S_LATCH: begin
            if (rd_out_ff) begin
               rdata_in = r_wide[31:0];
               state_in = S_DONE;
            end else begin
               t_in     = rd_data;
               state_in = S_RD;
            end
         end

         // Move loop: read the neighbor, then write it into the current entry.
         S_RD: begin
            rd_addr = down_ff ? i_m1[ADDR_BITS-1:0] : i_p1[ADDR_BITS-1:0];
            if (i_ff == end_ff) begin
               state_in = S_TAIL;
            end else begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[ADDR_BITS-1:0];
            wr_data  = rd_data;
            i_in     = down_ff ? i_m1 : i_p1;
            state_in = S_RD;
         end
         S_TAIL: begin
            wr_en    = tail_we_ff;
            wr_addr  = tail_addr_ff[ADDR_BITS-1:0];
            wr_data  = use_t_ff ? t_ff : tdat_ff;
            len_in   = len_nx_ff;
            state_in = S_DONE;
         end

         // Search scan; the previous word is kept for the transposition swap.
         S_SRCH_RD: begin
            rd_addr = i_ff[ADDR_BITS-1:0];
            if (i_ff == len_ff) begin
               status_in = alst_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               state_in = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (rd_data == x_ff) begin
               found_in = 6'(i_ff);
               if (i_ff != '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = i_m1[ADDR_BITS-1:0];
                  wr_data  = rd_data;
                  state_in = S_SWAP2;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               t_in     = rd_data;
               i_in     = i_p1;
               state_in = S_SRCH_RD;
            end
         end
         S_SWAP2: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[ADDR_BITS-1:0];
            wr_data  = t_ff;
            state_in = S_DONE;
         end

         // Reverse: swap the pair at the front and back pointers.
         S_REV_RA: begin
            rd_addr = i_ff[ADDR_BITS-1:0];
            if (i_ff < end_ff) begin
               state_in = S_REV_RB;
            end else begin
               state_in = S_DONE;
            end
         end
         S_REV_RB: begin
            t_in     = rd_data;
            rd_addr  = end_ff[ADDR_BITS-1:0];
            state_in = S_REV_WA;
         end
         S_REV_WA: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[ADDR_BITS-1:0];
            wr_data  = rd_data;
            state_in = S_REV_WB;
         end
         S_REV_WB: begin
            wr_en    = 1'b1;
            wr_addr  = end_ff[ADDR_BITS-1:0];
            wr_data  = t_ff;
            i_in     = i_p1;
            end_in   = b_m1;
            state_in = S_REV_RA;
         end

         // Sign partition with front and back pointers.
         S_PA: begin
            rd_addr = i_ff[ADDR_BITS-1:0];
            if (i_ff < end_ff) begin
               state_in = S_PA_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PA_CHK: begin
            if (rd_data[WORD_BITS-1]) begin
               i_in     = i_p1;
               state_in = S_PA;
            end else begin
               t_in     = rd_data;
               state_in = S_PB;
            end
         end
         S_PB: begin
            rd_addr = end_ff[ADDR_BITS-1:0];
            if (i_ff < end_ff) begin
               state_in = S_PB_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PB_CHK: begin
            if (!rd_data[WORD_BITS-1]) begin
               end_in   = b_m1;
               state_in = S_PB;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = i_ff[ADDR_BITS-1:0];
               wr_data  = rd_data;
               state_in = S_PW;
            end
         end
         S_PW: begin
            wr_en    = 1'b1;
            wr_addr  = end_ff[ADDR_BITS-1:0];
            wr_data  = t_ff;
            i_in     = i_p1;
            end_in   = b_m1;
            state_in = S_PA;
         end

         // Hold the result until the output stage takes it.
         S_DONE: begin
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      len_nx_ff    <= len_nx_in;
      i_ff         <= i_in;
      end_ff       <= end_in;
      down_ff      <= down_in;
      tail_we_ff   <= tail_we_in;
      use_t_ff     <= use_t_in;
      tail_addr_ff <= tail_addr_in;
      tdat_ff      <= tdat_in;
      t_ff         <= t_in;
      x_ff         <= x_in;
      tsrc_ff      <= tsrc_in;
      rd_out_ff    <= rd_out_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      rdata_ff     <= rdata_in;
   end

endmodule

`default_nettype wire

/* src/array_list_engine_core.sv */
// Array list engine: a dense list of signed words kept in one synchronous memory.
// Each request transaction carries one action (append, insert, drop last, delete
// at, search, reverse, shifts, rotates, sign partition, read) and yields exactly
// one response transaction with status, match index, read word and new length.
// The capacity register is written via csr_we/csr_wdata, by the user only while
// idle, which the block does not enforce; values are clamped to 1..DEPTH.
// One request is worked on at a time; req_bus.ready is high only while the
// sequencer is free. Every step is one memory access, so the time taken follows
// the entries touched: insert and delete move the entries from the position to
// the end, shifts and rotates move every entry, search scans up to the match,
// reverse swaps pairs from both ends inward, and partition examines entries
// from both ends and swaps each misplaced pair.
// A finished response sits in an output register; the next request is taken
// while it waits. If rsp_bus stalls with that register full, the sequencer holds
// its own result until the register drains.
// Reset (synchronous, active high) empties the list and sets capacity to DEPTH;
// entry contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_core #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   alst_req_if.sink          req_bus,
   alst_rsp_if.source        rsp_bus,
   input  wire logic         csr_we,
   input  wire logic [6:0]   csr_wdata
);

   localparam int LEN_BITS  = $clog2(DEPTH + 1);
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CW        = (LEN_BITS > 7) ? LEN_BITS : 7;

   logic [LEN_BITS-1:0]   cap_ff, cap_in;
   logic [CW-1:0]         cap_raw;
   logic                  seq_done, take;
   alst_pkg::rsp_type     seq_result;
   alst_pkg::rsp_type     out_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [WORD_BITS-1:0]  wr_data, rd_data;

   // Capacity register, clamped to the usable range when written.
   assign cap_raw = CW'(csr_wdata);
   always_comb begin
      cap_in = cap_ff;
      if (csr_we) begin
         if (cap_raw == '0) begin
            cap_in = LEN_BITS'(1);
         end else if (cap_raw > CW'(DEPTH)) begin
            cap_in = LEN_BITS'(DEPTH);
         end else begin
            cap_in = LEN_BITS'(cap_raw);
         end
      end
   end

   // Output register: loads when empty or drained in the same cycle.
   assign take = seq_done && (!out_valid_ff || rsp_bus.ready);
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= LEN_BITS'(DEPTH);
         out_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= seq_result;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_ff.status;
   assign rsp_bus.found_at    = out_ff.found_at;
   assign rsp_bus.read_data   = out_ff.read_data;
   assign rsp_bus.list_length = out_ff.list_length;

   alst_seq #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_action     (req_bus.action),
      .req_position   (req_bus.position),
      .req_item_value (req_bus.item_value),
      .capacity       (cap_ff),
      .done           (seq_done),
      .done_ack       (take),
      .result         (seq_result),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   alst_mem #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
